### rtl/rcpwm_pkg.sv
// Shared types and constants for the RC PWM capture block.
`timescale 1ns / 1ps
`default_nettype none

package rcpwm_pkg;

    localparam int DEF_CHANNELS = 8;
    localparam int NCH_MAX      = 8;
    localparam int CH_W         = 3;
    localparam int WIDTH_W      = 16;
    localparam int SHIFT_W      = 4;
    localparam int CFG_ADDR_W   = 3;

    localparam logic OP_PIN_EVENT = 1'b0;
    localparam logic OP_REPORT    = 1'b1;

    localparam logic [WIDTH_W-1:0] RESET_WIDTH      = 16'd3000;
    localparam logic [SHIFT_W-1:0] RESET_SHIFT      = 4'd1;
    localparam logic [NCH_MAX-1:0] RESET_INVERT     = 8'hFF;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH_MIN  = 16'd2000;
    localparam logic [WIDTH_W-1:0] RESET_WIDTH_MAX  = 16'd4000;
    localparam logic [WIDTH_W-1:0] RESET_CENTER     = 16'd3000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FILTER_ENABLE = 3'd0,
        REG_FILTER_SHIFT  = 3'd1,
        REG_INVERT_MASK   = 3'd2,
        REG_WIDTH_MIN     = 3'd3,
        REG_WIDTH_MAX     = 3'd4,
        REG_WIDTH_CENTER  = 3'd5
    } cfg_reg_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_REPORT
    } ctrl_state_t;

    typedef struct packed {
        logic            capture;
        logic            edge_step;
        logic            emit_step;
        logic [CH_W-1:0] chan;
        logic            last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/rcpwm_ctrl.sv
// Controller state machine that sequences channel steps for samples and reports.
`timescale 1ns / 1ps
`default_nettype none

module rcpwm_ctrl
    import rcpwm_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire logic    s_op,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    localparam int CNT_W = $clog2(CHANNELS + 1);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    state_next = (s_op == OP_REPORT) ? ST_REPORT : ST_SAMPLE;
                end
            end
            ST_SAMPLE: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CHANNELS)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (sts.out_free) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(CHANNELS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.capture   = 1'b0;
        cmd.edge_step = 1'b0;
        cmd.emit_step = 1'b0;
        cmd.chan      = CH_W'(cnt_reg);
        cmd.last      = (cnt_reg == CNT_W'(CHANNELS - 1));
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid & (s_op == OP_PIN_EVENT);
            end
            ST_SAMPLE: begin
                cmd.edge_step = (cnt_reg < CNT_W'(CHANNELS));
            end
            ST_REPORT: begin
                cmd.emit_step = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rcpwm_dp.sv
// Datapath: configuration, per-channel capture state, smoothing filter and axis output register.
`timescale 1ns / 1ps
`default_nettype none

module rcpwm_dp
    import rcpwm_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dp_cmd_t                  cmd,
    output dp_sts_t                       sts,
    input  wire logic [NCH_MAX-1:0]       s_pin_levels,
    input  wire logic [WIDTH_W-1:0]       s_time_stamp,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [WIDTH_W-1:0]       cfg_wdata,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CH_W-1:0]               m_channel,
    output logic signed [WIDTH_W-1:0]     m_axis_value,
    output logic                          m_last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                 filter_enable_reg;
    logic [SHIFT_W-1:0]   filter_shift_reg;
    logic [NCH_MAX-1:0]   invert_mask_reg;
    logic [WIDTH_W-1:0]   width_min_reg;
    logic [WIDTH_W-1:0]   width_max_reg;
    logic [WIDTH_W-1:0]   width_center_reg;

    logic [NCH_MAX-1:0]   prev_levels_reg;
    logic [NCH_MAX-1:0]   pins_reg;
    logic [NCH_MAX-1:0]   changed_reg;
    logic [WIDTH_W-1:0]   stamp_reg;

    logic [WIDTH_W-1:0]   rise_time_reg [CHANNELS];
    logic [WIDTH_W-1:0]   raw_width_reg [CHANNELS];
    logic [WIDTH_W-1:0]   smoothed_reg  [CHANNELS];
    logic [CHANNELS-1:0]  armed_reg;

    logic                 fpend_reg;
    logic [IDX_W-1:0]     fidx_reg;

    logic                 m_valid_reg;
    logic [CH_W-1:0]      m_channel_reg;
    logic [WIDTH_W-1:0]   m_axis_reg;
    logic                 m_last_reg;

    logic [IDX_W-1:0]     idx;
    logic                 ch_changed;
    logic                 ch_level;
    logic                 rise_take;
    logic                 fall_take;
    logic [WIDTH_W-1:0]   width_new;

    logic [WIDTH_W-1:0]   diff;
    logic signed [WIDTH_W:0]   step;
    logic signed [WIDTH_W+1:0] sum;
    logic [WIDTH_W-1:0]   smooth_next;

    logic [WIDTH_W-1:0]   sel_width;
    logic [WIDTH_W-1:0]   lo_width;
    logic [WIDTH_W-1:0]   clamp_width;
    logic [WIDTH_W-1:0]   centered;
    logic [WIDTH_W-1:0]   axis_next;

    assign idx        = cmd.chan[IDX_W-1:0];
    assign ch_changed = changed_reg[cmd.chan];
    assign ch_level   = pins_reg[cmd.chan];
    assign rise_take  = cmd.edge_step & ch_changed & ch_level;
    assign fall_take  = cmd.edge_step & ch_changed & ~ch_level & armed_reg[idx];
    assign width_new  = stamp_reg - rise_time_reg[idx];

    always_comb begin
        diff = raw_width_reg[fidx_reg] - smoothed_reg[fidx_reg];
        step = $signed({diff[WIDTH_W-1], diff}) >>> filter_shift_reg;
        sum  = $signed({2'b00, smoothed_reg[fidx_reg]}) + $signed({step[WIDTH_W], step});
        if (sum[WIDTH_W+1]) begin
            smooth_next = '0;
        end else if (sum[WIDTH_W]) begin
            smooth_next = '1;
        end else begin
            smooth_next = sum[WIDTH_W-1:0];
        end
    end

    always_comb begin
        sel_width   = filter_enable_reg ? smoothed_reg[idx] : raw_width_reg[idx];
        lo_width    = (sel_width < width_min_reg) ? width_min_reg : sel_width;
        clamp_width = (lo_width > width_max_reg) ? width_max_reg : lo_width;
        centered    = clamp_width - width_center_reg;
        axis_next   = invert_mask_reg[cmd.chan] ? (WIDTH_W'(0) - centered) : centered;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_enable_reg <= 1'b0;
            filter_shift_reg  <= RESET_SHIFT;
            invert_mask_reg   <= RESET_INVERT;
            width_min_reg     <= RESET_WIDTH_MIN;
            width_max_reg     <= RESET_WIDTH_MAX;
            width_center_reg  <= RESET_CENTER;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FILTER_ENABLE: filter_enable_reg <= cfg_wdata[0];
                REG_FILTER_SHIFT:  filter_shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                REG_INVERT_MASK:   invert_mask_reg   <= cfg_wdata[NCH_MAX-1:0];
                REG_WIDTH_MIN:     width_min_reg     <= cfg_wdata;
                REG_WIDTH_MAX:     width_max_reg     <= cfg_wdata;
                REG_WIDTH_CENTER:  width_center_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pins_reg    <= s_pin_levels;
            changed_reg <= s_pin_levels ^ prev_levels_reg;
            stamp_reg   <= s_time_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
            armed_reg       <= '0;
            fpend_reg       <= 1'b0;
            fidx_reg        <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                rise_time_reg[i] <= '0;
                raw_width_reg[i] <= RESET_WIDTH;
                smoothed_reg[i]  <= RESET_WIDTH;
            end
        end else begin
            if (cmd.capture) begin
                prev_levels_reg <= s_pin_levels;
            end
            if (rise_take) begin
                rise_time_reg[idx] <= stamp_reg;
                armed_reg[idx]     <= 1'b1;
            end
            if (fall_take) begin
                raw_width_reg[idx] <= width_new;
                armed_reg[idx]     <= 1'b0;
            end
            fpend_reg <= fall_take & filter_enable_reg;
            fidx_reg  <= idx;
            if (fpend_reg) begin
                smoothed_reg[fidx_reg] <= smooth_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            m_channel_reg <= cmd.chan;
            m_axis_reg    <= axis_next;
            m_last_reg    <= cmd.last;
        end
    end

    assign sts.out_free  = ~m_valid_reg | m_ready;
    assign m_valid       = m_valid_reg;
    assign m_channel     = m_channel_reg;
    assign m_axis_value  = $signed(m_axis_reg);
    assign m_last        = m_last_reg;

endmodule

`default_nettype wire

### rtl/rc_pwm_capture_to_axes.sv
// Top level of the RC PWM pulse-width capture block with axis reporting.
// A pin-sample transaction is accepted while the controller is idle and then steps through
// the channels, one channel edge step per cycle through the shared capture and filter path.
// A report transaction emits CHANNELS results, one per cycle while m_ready is high;
// the first result is registered in the report state once the output register is free.
// Reset is synchronous and active low; it restores the config registers, control state and per-channel state.
`timescale 1ns / 1ps
`default_nettype none

module rc_pwm_capture_to_axes
    import rcpwm_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_op,
    input  wire logic [NCH_MAX-1:0]       s_pin_levels,
    input  wire logic [WIDTH_W-1:0]       s_time_stamp,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CH_W-1:0]               m_channel,
    output logic signed [WIDTH_W-1:0]     m_axis_value,
    output logic                          m_last,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [WIDTH_W-1:0]       cfg_wdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rcpwm_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .sts     (sts),
        .cmd     (cmd)
    );

    rcpwm_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_pin_levels (s_pin_levels),
        .s_time_stamp (s_time_stamp),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_channel    (m_channel),
        .m_axis_value (m_axis_value),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
